// File: rtl/core/acia_serial_register_front_defines.svh
`ifndef ACIA_SERIAL_REGISTER_FRONT_DEFINES_SVH
`define ACIA_SERIAL_REGISTER_FRONT_DEFINES_SVH

`ifndef SYNTHESIS
`define ASRF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASRF_ASSERT_ALWAYS(lbl, expr, msg)
`define ASRF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/asrf_pkg.sv
package asrf_pkg;

  localparam int RX_DEPTH = 8;
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_LINE  = 2'd2;

  localparam logic [3:0] OFF_DIP1   = 4'd1;
  localparam logic [3:0] OFF_DIP2   = 4'd2;
  localparam logic [3:0] OFF_DATA   = 4'd8;
  localparam logic [3:0] OFF_STATUS = 4'd9;
  localparam logic [3:0] OFF_CMD    = 4'd10;
  localparam logic [3:0] OFF_CTL    = 4'd11;

  localparam logic CFG_PORT_OPEN = 1'b0;
  localparam logic CFG_FILE_MODE = 1'b1;

  localparam logic [7:0] DIP1_VAL       = 8'hF0;
  localparam logic [7:0] DIP2_VAL       = 8'hD0;
  localparam logic [7:0] STAT_CLOSED    = 8'h70;
  localparam logic [7:0] STAT_BASE      = 8'h10;
  localparam logic [7:0] STAT_RX_FULL   = 8'h08;
  localparam logic [7:0] STAT_NO_DCD    = 8'h20;
  localparam logic [7:0] STAT_NO_DSR    = 8'h40;
  localparam logic [7:0] TX_FILE_MASK   = 8'h7F;
  localparam logic [7:0] CMD_RESET_VAL  = 8'h00;
  localparam logic [7:0] CTL_RESET_VAL  = 8'h1F;

  localparam logic [2:0] PAR_NONE  = 3'd0;
  localparam logic [1:0] STOP_ONE  = 2'd0;
  localparam logic [1:0] STOP_ONE_HALF = 2'd1;
  localparam logic [1:0] STOP_TWO  = 2'd2;
  localparam logic [2:0] BAUD_RESET = 3'd7;
  localparam logic [3:0] BITS_RESET = 4'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_offset;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
    logic       carrier_on;
    logic       dsr_on;
  } asrf_item_t;

  typedef struct packed {
    logic [2:0] baud_code;
    logic [3:0] data_bits;
    logic [2:0] parity_mode;
    logic [1:0] stop_mode;
  } asrf_line_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       line_changed;
    asrf_line_t line;
    logic       rx_dropped;
  } asrf_result_t;

  typedef struct packed {
    logic       cmd_wr;
    logic       ctl_wr;
    logic [7:0] data;
  } asrf_line_wr_t;

  typedef struct packed {
    logic push;
    logic pop;
  } asrf_fifo_ctl_t;

  typedef struct packed {
    logic       not_empty;
    logic       full;
    logic [7:0] head_data;
  } asrf_fifo_stat_t;

  function automatic logic [2:0] baud_decode(input logic [3:0] code);
    logic [2:0] b;
    case (code)
      4'd6:          b = 3'd1;
      4'd7:          b = 3'd2;
      4'd8:          b = 3'd3;
      4'd9, 4'd10:   b = 3'd4;
      4'd11, 4'd12:  b = 3'd5;
      4'd13, 4'd14:  b = 3'd6;
      4'd15:         b = 3'd7;
      default:       b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/asrf_if.sv
interface asrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] reg_offset;
  logic [7:0] wdata;
  logic [7:0] rx_byte;
  logic       carrier_on;
  logic       dsr_on;

  modport source (output valid, output req_type, output reg_offset, output wdata,
                  output rx_byte, output carrier_on, output dsr_on, input ready);
  modport sink   (input valid, input req_type, input reg_offset, input wdata,
                  input rx_byte, input carrier_on, input dsr_on, output ready);
endinterface

interface asrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       line_changed;
  logic [2:0] baud_code;
  logic [3:0] data_bits;
  logic [2:0] parity_mode;
  logic [1:0] stop_mode;
  logic       rx_dropped;

  modport source (output valid, output read_data, output tx_valid, output tx_byte,
                  output line_changed, output baud_code, output data_bits,
                  output parity_mode, output stop_mode, output rx_dropped, input ready);
  modport sink   (input valid, input read_data, input tx_valid, input tx_byte,
                  input line_changed, input baud_code, input data_bits,
                  input parity_mode, input stop_mode, input rx_dropped, output ready);
endinterface

// File: rtl/core/asrf_line_cfg.sv
module asrf_line_cfg
  import asrf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  asrf_line_wr_t wr,
  output logic [7:0]    command_q,
  output logic [7:0]    control_q,
  output logic          changed,
  output asrf_line_t    line_nxt
);

  logic [7:0] command_r, command_nxt;
  logic [7:0] control_r, control_nxt;
  asrf_line_t line_r;
  logic [3:0] bits_new;
  logic [1:0] stop_new;

  always_comb begin
    bits_new = 4'd8 - {2'b00, wr.data[6:5]};
    if (!wr.data[7]) begin
      stop_new = STOP_ONE;
    end else if (bits_new == 4'd8 && line_r.parity_mode == PAR_NONE) begin
      stop_new = STOP_ONE;
    end else if (bits_new == 4'd5 && line_r.parity_mode == PAR_NONE) begin
      stop_new = STOP_ONE_HALF;
    end else begin
      stop_new = STOP_TWO;
    end
  end

  always_comb begin
    command_nxt = command_r;
    control_nxt = control_r;
    line_nxt    = line_r;
    changed     = 1'b0;
    if (wr.cmd_wr && wr.data != command_r) begin
      command_nxt = wr.data;
      changed     = 1'b1;
      line_nxt.parity_mode = wr.data[5] ? (3'd1 + {1'b0, wr.data[7:6]}) : PAR_NONE;
    end else if (wr.ctl_wr && wr.data != control_r) begin
      control_nxt = wr.data;
      changed     = 1'b1;
      line_nxt.baud_code = baud_decode(wr.data[3:0]);
      line_nxt.data_bits = bits_new;
      line_nxt.stop_mode = stop_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r <= CMD_RESET_VAL;
      control_r <= CTL_RESET_VAL;
      line_r    <= '{baud_code: BAUD_RESET, data_bits: BITS_RESET,
                     parity_mode: PAR_NONE, stop_mode: STOP_ONE};
    end else begin
      command_r <= command_nxt;
      control_r <= control_nxt;
      line_r    <= line_nxt;
    end
  end

  assign command_q = command_r;
  assign control_q = control_r;

endmodule

// File: rtl/core/asrf_rx_fifo.sv
`include "acia_serial_register_front_defines.svh"

module asrf_rx_fifo
  import asrf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  asrf_fifo_ctl_t  ctl,
  input  logic [7:0]      push_data,
  output asrf_fifo_stat_t stat
);

  localparam int SUM_W = RX_CNT_W + 1;

  logic [7:0]          store_r [RX_DEPTH];
  logic [RX_PTR_W-1:0] head_r, head_nxt;
  logic [RX_CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]    tail_sum;
  logic [RX_PTR_W-1:0] tail;

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= SUM_W'(RX_DEPTH)) begin
      tail = RX_PTR_W'(tail_sum - SUM_W'(RX_DEPTH));
    end else begin
      tail = RX_PTR_W'(tail_sum);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop && count_r != '0) begin
      head_nxt  = (head_r == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (ctl.push && count_r != RX_CNT_W'(RX_DEPTH)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.pop && count_r != RX_CNT_W'(RX_DEPTH)) begin
      store_r[tail] <= push_data;
    end
  end

  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == RX_CNT_W'(RX_DEPTH));
  assign stat.head_data = store_r[head_r];

  `ASRF_ASSERT_ALWAYS(a_count_bound, count_r <= RX_CNT_W'(RX_DEPTH), "rx fifo overfilled")
  `ASRF_ASSERT_NEXT(a_push_grows, ctl.push && !ctl.pop && !stat.full, count_r == $past(count_r) + 1'b1, "push lost")
  `ASRF_ASSERT_NEXT(a_pop_shrinks, ctl.pop && stat.not_empty, count_r == $past(count_r) - 1'b1, "pop lost")

endmodule

// File: rtl/core/acia_serial_register_front.sv
// Register front end of a 6551-style serial card.
// in_ch carries one word per bus read, bus write or byte arriving from the line;
// out_ch returns exactly one result word for each, in order.
// Configuration (port_open at 0x0, file_mode at 0x4) is written over the APB port.
// A word accepted from in_ch is registered in the input register, decoded, and its
// result is registered in the result register, which drives out_ch.valid.
// Throughput: one word per cycle while out_ch.ready stays high; the input register
// and the result register each advance whenever the stage after them is empty or being drained.
// Receiver stall: the result register holds and the input register fills, then
// in_ch.ready falls until out_ch.ready returns; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties both registers and the receive FIFO,
// closes the port and returns the line settings to 19200 baud, 8 data bits,
// no parity, one stop bit.
module acia_serial_register_front
  import asrf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  asrf_in_if.sink      in_ch,
  asrf_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic            port_open_r, file_mode_r;
  logic            s1_valid_r;
  asrf_item_t      s1_item_r;
  logic            res_valid_r;
  asrf_result_t    res_r, res_nxt;
  logic            res_adv, s1_fire;
  asrf_line_wr_t   line_wr;
  logic [7:0]      command_q, control_q;
  logic            line_chg;
  asrf_line_t      line_nxt;
  asrf_fifo_ctl_t  fifo_ctl;
  asrf_fifo_stat_t fifo_stat;
  logic [7:0]      status_val;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_FILE_MODE) ? {31'd0, file_mode_r} : {31'd0, port_open_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_open_r <= 1'b0;
      file_mode_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == CFG_PORT_OPEN) begin
        port_open_r <= pwdata[0];
      end else begin
        file_mode_r <= pwdata[0];
      end
    end
  end

  assign res_adv     = !res_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && res_adv;
  assign in_ch.ready = !s1_valid_r || res_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= '{req_type: in_ch.req_type, reg_offset: in_ch.reg_offset,
                     wdata: in_ch.wdata, rx_byte: in_ch.rx_byte,
                     carrier_on: in_ch.carrier_on, dsr_on: in_ch.dsr_on};
    end
  end

  asrf_line_cfg u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (line_wr),
    .command_q (command_q),
    .control_q (control_q),
    .changed   (line_chg),
    .line_nxt  (line_nxt)
  );

  asrf_rx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .push_data (s1_item_r.rx_byte),
    .stat      (fifo_stat)
  );

  always_comb begin
    status_val = STAT_BASE;
    if (fifo_stat.not_empty) status_val = status_val | STAT_RX_FULL;
    if (!s1_item_r.carrier_on) status_val = status_val | STAT_NO_DCD;
    if (!s1_item_r.dsr_on) status_val = status_val | STAT_NO_DSR;
  end

  always_comb begin
    line_wr      = '{cmd_wr: 1'b0, ctl_wr: 1'b0, data: s1_item_r.wdata};
    fifo_ctl     = '0;
    res_nxt      = '0;
    case (s1_item_r.req_type)
      REQ_READ: begin
        case (s1_item_r.reg_offset)
          OFF_DIP1: res_nxt.read_data = DIP1_VAL;
          OFF_DIP2: res_nxt.read_data = DIP2_VAL;
          OFF_STATUS: begin
            if (!port_open_r) begin
              res_nxt.read_data = STAT_CLOSED;
            end else if (file_mode_r) begin
              res_nxt.read_data = STAT_BASE;
            end else begin
              res_nxt.read_data = status_val;
            end
          end
          OFF_DATA: begin
            if (port_open_r && !file_mode_r && fifo_stat.not_empty) begin
              res_nxt.read_data = fifo_stat.head_data;
              fifo_ctl.pop      = s1_fire;
            end
          end
          OFF_CMD: res_nxt.read_data = port_open_r ? command_q : 8'd0;
          OFF_CTL: res_nxt.read_data = port_open_r ? control_q : 8'd0;
          default: res_nxt.read_data = 8'd0;
        endcase
      end
      REQ_WRITE: begin
        if (port_open_r) begin
          case (s1_item_r.reg_offset)
            OFF_DATA: begin
              res_nxt.tx_valid = 1'b1;
              res_nxt.tx_byte  = file_mode_r ? (s1_item_r.wdata & TX_FILE_MASK)
                                             : s1_item_r.wdata;
            end
            OFF_CMD: line_wr.cmd_wr = s1_fire;
            OFF_CTL: line_wr.ctl_wr = s1_fire;
            default: ;
          endcase
        end
      end
      REQ_LINE: begin
        if (port_open_r) begin
          if (fifo_stat.full) begin
            res_nxt.rx_dropped = 1'b1;
          end else begin
            fifo_ctl.push = s1_fire;
          end
        end
      end
      default: ;
    endcase
    res_nxt.line_changed = line_chg;
    res_nxt.line         = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_adv) begin
      res_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = res_valid_r;
  assign out_ch.read_data    = res_r.read_data;
  assign out_ch.tx_valid     = res_r.tx_valid;
  assign out_ch.tx_byte      = res_r.tx_byte;
  assign out_ch.line_changed = res_r.line_changed;
  assign out_ch.baud_code    = res_r.line.baud_code;
  assign out_ch.data_bits    = res_r.line.data_bits;
  assign out_ch.parity_mode  = res_r.line.parity_mode;
  assign out_ch.stop_mode    = res_r.line.stop_mode;
  assign out_ch.rx_dropped   = res_r.rx_dropped;

endmodule
